@@ hw/rtl/rational_arithmetic_unit_defines.svh @@
// Assertion macros shared by the checker.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rau_pkg.sv @@
package rau_pkg;
  localparam int MAG_W  = 32;
  localparam int PROD_W = 64;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;
  localparam logic [2:0] OP_INV = 3'd5;
  localparam logic [2:0] OP_RED = 3'd6;
  localparam logic [2:0] OP_BAD = 3'd7;

  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [PROD_W-1:0] prod_t;
endpackage

@@ hw/rtl/rau_mul.sv @@
module rau_mul
  import rau_pkg::*;
#(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   mcand,
  input  logic [W-1:0]   mplier,
  output logic           done,
  output logic [2*W-1:0] prod
);
  localparam int CNT_W = $clog2(W + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       hi;
  logic [W-1:0]     lo;
  logic [W-1:0]     md;
  logic [W:0]       sum;

  assign sum  = hi + (lo[0] ? {1'b0, md} : '0);
  assign prod = {hi[W-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        hi  <= '0;
        lo  <= mplier;
        md  <= mcand;
      end else if (run) begin
        // add then shift one multiplier bit out
        hi  <= {1'b0, sum[W:1]};
        lo  <= {sum[0], lo[W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hw/rtl/rau_div.sv @@
module rau_div
  import rau_pkg::*;
#(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot
);
  localparam int CNT_W = $clog2(W + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvs;
  logic [W:0]       sh;
  logic [W:0]       diff;
  logic             ge;

  assign sh   = {rem, quot[W-1]};
  assign diff = sh - {1'b0, dvs};
  assign ge   = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quot <= dividend;
        dvs  <= divisor;
      end else if (run) begin
        rem  <= ge ? diff[W-1:0] : sh[W-1:0];
        quot <= {quot[W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hw/rtl/rational_arithmetic_unit.sv @@
// Rational ALU: one fraction operation per start beat, result on one done strobe.
// An operand error (zero denominator, divide by zero, invert of zero, bad opcode)
// answers in the cycle after start. Otherwise an item runs the bit-serial cross
// products and takes them, then the binary gcd loop (one shift or subtract per
// cycle), then restores the common power of two, and last runs the bit-serial
// quotients. Compare and zero results leave after the product stage. Results
// cannot be held off; busy stays high until done.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic               done,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               less,
  output logic               equal,
  output logic               greater,
  output logic               error,
  output logic               overflow
);
  localparam int    EFF    = (WIDTH > 32) ? 32 : WIDTH;
  localparam prod_t MAXPOS = (prod_t'(1) << (EFF - 1)) - prod_t'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_GCD  = 3'd2;
  localparam logic [2:0] S_GSH  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;

  logic [2:0] state;
  logic       accept;

  mag_t an_m, ad_m, bn_m, bd_m;
  logic a_ng, b_ng, b_eff, err_in;
  mag_t m0a, m0b, m1a, m1b, m2a, m2b;

  logic [2:0] op;
  logic       aneg, bneg;
  logic       m0_done, m1_done, m2_done, d0_done, d1_done;
  prod_t      p0, p1, p2, q0, q1;

  prod_t c_num, c_den;
  logic  c_neg;
  prod_t u, v, num_r, den_r;
  logic [5:0] k;
  logic  sneg;
  logic  ovf;

  function automatic mag_t mag_of(input logic [31:0] x);
    mag_of = x[31] ? (~x + 32'd1) : x;
  endfunction

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_comb begin
    an_m  = mag_of(a_num);
    ad_m  = mag_of(a_den);
    bn_m  = mag_of(b_num);
    bd_m  = mag_of(b_den);
    a_ng  = (an_m != '0) && (a_num[31] ^ a_den[31]);
    b_ng  = (bn_m != '0) && (b_num[31] ^ b_den[31]);
    b_eff = (opcode == OP_SUB) ? ((bn_m != '0) && !b_ng) : b_ng;
    err_in = (opcode == OP_BAD) || (ad_m == '0) ||
             ((opcode <= OP_CMP) && (bd_m == '0)) ||
             ((opcode == OP_DIV) && (bn_m == '0)) ||
             ((opcode == OP_INV) && (an_m == '0));
    m0a = an_m; m0b = bd_m;
    m1a = bn_m; m1b = ad_m;
    m2a = ad_m; m2b = bd_m;
    unique case (opcode)
      OP_MUL: begin
        m0b = bn_m;
      end
      OP_DIV: begin
        m2b = bn_m;
      end
      OP_INV: begin
        m0a = ad_m; m0b = 32'd1;
        m2a = an_m; m2b = 32'd1;
      end
      OP_RED: begin
        m0b = 32'd1;
        m2b = 32'd1;
      end
      default: begin
      end
    endcase
  end

  rau_mul #(.W(MAG_W)) u_mul0 (
    .clk(clk), .rst(rst), .start(accept && !err_in),
    .mcand(m0a), .mplier(m0b), .done(m0_done), .prod(p0)
  );
  rau_mul #(.W(MAG_W)) u_mul1 (
    .clk(clk), .rst(rst), .start(accept && !err_in),
    .mcand(m1a), .mplier(m1b), .done(m1_done), .prod(p1)
  );
  rau_mul #(.W(MAG_W)) u_mul2 (
    .clk(clk), .rst(rst), .start(accept && !err_in),
    .mcand(m2a), .mplier(m2b), .done(m2_done), .prod(p2)
  );

  rau_div #(.W(PROD_W)) u_div0 (
    .clk(clk), .rst(rst), .start(state == S_GSH && k == '0),
    .dividend(num_r), .divisor(u), .done(d0_done), .quot(q0)
  );
  rau_div #(.W(PROD_W)) u_div1 (
    .clk(clk), .rst(rst), .start(state == S_GSH && k == '0),
    .dividend(den_r), .divisor(u), .done(d1_done), .quot(q1)
  );

  // combine the cross products into one magnitude and sign
  always_comb begin
    c_num = p0;
    c_den = p2;
    c_neg = aneg ^ bneg;
    unique case (op)
      OP_ADD, OP_SUB: begin
        if (aneg == bneg) begin
          c_num = p0 + p1;
          c_neg = aneg;
        end else if (p0 >= p1) begin
          c_num = p0 - p1;
          c_neg = aneg;
        end else begin
          c_num = p1 - p0;
          c_neg = bneg;
        end
      end
      OP_INV, OP_RED: c_neg = aneg;
      default: begin
      end
    endcase
  end

  assign ovf = (q1 > MAXPOS) || (sneg ? (q0 > MAXPOS + prod_t'(1)) : (q0 > MAXPOS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op   <= opcode;
            aneg <= a_ng;
            bneg <= b_eff;
            if (err_in) begin
              done     <= 1'b1;
              res_num  <= '0;
              res_den  <= '0;
              less     <= 1'b0;
              equal    <= 1'b0;
              greater  <= 1'b0;
              error    <= 1'b1;
              overflow <= 1'b0;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (m0_done && m1_done && m2_done) begin
            less     <= 1'b0;
            equal    <= 1'b0;
            greater  <= 1'b0;
            error    <= 1'b0;
            overflow <= 1'b0;
            if (op == OP_CMP) begin
              done    <= 1'b1;
              state   <= S_IDLE;
              res_num <= '0;
              res_den <= '0;
              if (aneg != bneg) begin
                less    <= aneg;
                greater <= !aneg;
              end else if (p0 == p1) begin
                equal <= 1'b1;
              end else begin
                less    <= aneg ? (p0 > p1) : (p0 < p1);
                greater <= aneg ? (p0 < p1) : (p0 > p1);
              end
            end else if (c_num == '0) begin
              done    <= 1'b1;
              state   <= S_IDLE;
              res_num <= '0;
              res_den <= 31'd1;
            end else begin
              state <= S_GCD;
              u     <= c_num;
              v     <= c_den;
              num_r <= c_num;
              den_r <= c_den;
              sneg  <= c_neg;
              k     <= '0;
            end
          end
        end
        S_GCD: begin
          // binary gcd: one shift or subtract per cycle
          if (u == v) begin
            state <= S_GSH;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u > v) begin
            u <= (u - v) >> 1;
          end else begin
            v <= (v - u) >> 1;
          end
        end
        S_GSH: begin
          // restore the common power of two, then divide
          if (k == '0) begin
            state <= S_DIV;
          end else begin
            u <= u << 1;
            k <= k - 1'b1;
          end
        end
        S_DIV: begin
          if (d0_done && d1_done) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (ovf) begin
              overflow <= 1'b1;
              res_num  <= '0;
              res_den  <= '0;
            end else begin
              res_num <= sneg ? (32'd0 - q0[31:0]) : q0[31:0];
              res_den <= q1[30:0];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/rau_checker.sv @@
`include "rational_arithmetic_unit_defines.svh"

module rau_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] res_num,
  input logic [30:0]        res_den,
  input logic               less,
  input logic               equal,
  input logic               greater,
  input logic               error,
  input logic               overflow
);
  logic fault;
  logic flagged;

  assign fault   = error || overflow;
  assign flagged = fault || less || equal || greater;

  `RAU_ASSERT_NOW(a_cmp_onehot, done, $onehot0({less, equal, greater}), "compare flags clash")
  `RAU_ASSERT_NOW(a_err_zero, done && fault, res_num == 0 && res_den == 0, "error beat has data")
  `RAU_ASSERT_NOW(a_den_nonzero, done && !flagged, res_den != 0, "zero denominator on good beat")
  `RAU_ASSERT_NOW(a_done_idle, done, !busy, "result beat while busy")
  `RAU_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done, "accepted item dropped")
endmodule

bind rational_arithmetic_unit rau_port_checker u_rau_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .res_num(res_num), .res_den(res_den), .less(less), .equal(equal),
  .greater(greater), .error(error), .overflow(overflow)
);

@@ dv/rau_checker.sv @@
`timescale 1ns / 100ps

module rau_checker
  import rau_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  input  logic               done,
  input  logic signed [31:0] res_num,
  input  logic [30:0]        res_den,
  input  logic               less,
  input  logic               equal,
  input  logic               greater,
  input  logic               error,
  input  logic               overflow,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count
);
  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        err;
    logic        ovf;
  } outcome_t;

  outcome_t expected_q[$];

  // Sign and magnitude of a 32-bit two's complement value.
  function automatic logic [64:0] to_mag(logic [31:0] v);
    logic [63:0] m;
    m = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    return {v[31], m};
  endfunction

  function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic outcome_t pack_fraction(logic neg, logic [63:0] n, logic [63:0] d);
    outcome_t o;
    logic [63:0] g;
    logic [63:0] maxpos;
    o = '0;
    maxpos = 64'h7FFF_FFFF;
    if (n == 0) begin
      o.den = 31'd1;
      return o;
    end
    g = euclid(n, d);
    n = n / g;
    d = d / g;
    if (d > maxpos || (neg ? (n > maxpos + 1) : (n > maxpos))) begin
      o.ovf = 1'b1;
      return o;
    end
    o.num = neg ? (32'd0 - n[31:0]) : n[31:0];
    o.den = d[30:0];
    return o;
  endfunction

  function automatic outcome_t compute_result(logic [2:0] op, logic [31:0] an,
      logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    outcome_t o;
    logic [64:0] t;
    logic an_s, ad_s, bn_s, bd_s, aneg, bneg, sneg, lt;
    logic [63:0] anm, adm, bnm, bdm, x, y;
    o = '0;
    t = to_mag(an); an_s = t[64]; anm = t[63:0];
    t = to_mag(ad); ad_s = t[64]; adm = t[63:0];
    t = to_mag(bn); bn_s = t[64]; bnm = t[63:0];
    t = to_mag(bd); bd_s = t[64]; bdm = t[63:0];
    aneg = (anm != 0) && (an_s != ad_s);
    bneg = (bnm != 0) && (bn_s != bd_s);
    if (op == OP_BAD || adm == 0 || (op <= OP_CMP && bdm == 0)) begin
      o.err = 1'b1;
      return o;
    end
    x = anm * bdm;
    y = bnm * adm;
    case (op)
      OP_ADD, OP_SUB: begin
        sneg = (op == OP_SUB) ? (bnm != 0 && !bneg) : bneg;
        if (aneg == sneg) o = pack_fraction(aneg, x + y, adm * bdm);
        else if (x >= y) o = pack_fraction(aneg, x - y, adm * bdm);
        else o = pack_fraction(sneg, y - x, adm * bdm);
      end
      OP_MUL: o = pack_fraction(aneg != bneg, anm * bnm, adm * bdm);
      OP_DIV: begin
        if (bnm == 0) o.err = 1'b1;
        else o = pack_fraction(aneg != bneg, x, adm * bnm);
      end
      OP_CMP: begin
        if (aneg != bneg) begin
          o.lt = aneg;
          o.gt = !aneg;
        end else if (x == y) begin
          o.eq = 1'b1;
        end else begin
          lt = aneg ? (x > y) : (x < y);
          o.lt = lt;
          o.gt = !lt;
        end
      end
      OP_INV: begin
        if (anm == 0) o.err = 1'b1;
        else o = pack_fraction(aneg, adm, anm);
      end
      default: o = pack_fraction(aneg, anm, adm);
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (done) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.num !== res_num || want.den !== res_den || want.lt !== less ||
              want.eq !== equal || want.gt !== greater || want.err !== error ||
              want.ovf !== overflow) begin
            if (want.num !== res_num)
              $error("res_num: expected %0d, got %0d", $signed(want.num), res_num);
            if (want.den !== res_den)
              $error("res_den: expected %0d, got %0d", want.den, res_den);
            if (want.lt !== less) $error("less: expected %0b, got %0b", want.lt, less);
            if (want.eq !== equal) $error("equal: expected %0b, got %0b", want.eq, equal);
            if (want.gt !== greater)
              $error("greater: expected %0b, got %0b", want.gt, greater);
            if (want.err !== error) $error("error: expected %0b, got %0b", want.err, error);
            if (want.ovf !== overflow)
              $error("overflow: expected %0b, got %0b", want.ovf, overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_q.insert(expected_q.size(),
                          compute_result(opcode, a_num, a_den, b_num, b_den));
    end
    pending = expected_q.size();
  end
endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench
  import rau_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [2:0] opcode = OP_ADD;
  logic signed [31:0] a_num = '0, a_den = 32'sd1, b_num = '0, b_den = 32'sd1;
  logic signed [31:0] res_num;
  logic [30:0] res_den;
  logic less, equal, greater, error, overflow;
  int fail_count, pending, result_count;
  int idle_pct;
  int item_count = 0;
  int quiet_cycles = 0;
  logic [31:0] corner[8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h8000_0001, 32'h2, 32'hFFFF_FFFE};

  always #5 clk = ~clk;

  rational_arithmetic_unit DUT (.*);

  rau_checker u_checker (.*);

  // Called at a falling edge; returns at the falling edge after the accept with
  // start still high, so the caller must drop it before waiting.
  task automatic send_beat(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
      logic [31:0] bn, logic [31:0] bd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    opcode <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    item_count++;
  endtask

  // Half the picks are small operands so results reduce and fit; wide ones hit overflow.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return corner[$urandom_range(7)];
      1: return $urandom();
      2: return $urandom() >>> $urandom_range(31);
      default: return 32'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_pct = 29;

    for (int op = 0; op < 8; op++) begin
      send_beat(3'(op), 32'sd6, 32'sd4, -32'sd3, 32'sd9);
      send_beat(3'(op), corner[op], corner[(op + 3) % 8], corner[(op + 4) % 8],
                corner[(op + 5) % 8]);
    end
    send_beat(OP_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd1);
    send_beat(OP_MUL, 32'sd1, 32'sd1, 32'sd1, 32'sd0);
    send_beat(OP_DIV, 32'sd5, 32'sd3, 32'sd0, 32'sd7);
    send_beat(OP_INV, 32'sd0, 32'sd5, 32'sd0, 32'sd0);
    send_beat(OP_RED, 32'sd0, -32'sd5, 32'sd0, 32'sd0);
    send_beat(OP_CMP, 32'sd2, -32'sd4, -32'sd1, 32'sd2);
    send_beat(OP_RED, 32'h8000_0000, 32'sd1, 32'sd0, 32'sd0);
    send_beat(OP_RED, 32'h8000_0000, -32'sd1, 32'sd0, 32'sd0);
    send_beat(OP_MUL, 32'h7FFF_FFFF, 32'sd1, 32'h7FFF_FFFF, 32'sd1);

    // Hold until the block has drained.
    start <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < 400; i++) begin
      if (i == 130) idle_pct = 61;
      if (i == 260) idle_pct = 0;
      send_beat($urandom_range(99) < 95 ? 3'($urandom_range(6)) : OP_BAD,
                pick_value(), pick_value(), pick_value(), pick_value());
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d beats, %0d results: all opcodes, zero denominators,", item_count,
             result_count);
    $display("extreme operands, overflow, and sender idling at 29, 61 and 0 percent.");
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

@@ rational_arithmetic_unit.f @@
+incdir+hw/rtl
hw/rtl/rau_pkg.sv
hw/rtl/rau_mul.sv
hw/rtl/rau_div.sv
hw/rtl/rational_arithmetic_unit.sv
hw/rtl/rau_checker.sv
dv/rau_checker.sv
dv/testbench.sv
